### design/sdmc_pkg.sv
// ----------------------------------------------------------------------------
// sdmc_pkg: shared types and tables of the segment display mode controller
// Character codes, operation codes, mode encoding, the draw command that
// travels from front to back, and the glyph, word and fraction tables.
// ----------------------------------------------------------------------------
package sdmc_pkg;

   // Character code of one display digit
   typedef logic [5:0] char_type;

   // Operation codes of the request channel
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_SPEED   = 3'd1;
   localparam logic [2:0] OP_FLASH   = 3'd2;
   localparam logic [2:0] OP_TEMP    = 3'd3;
   localparam logic [2:0] OP_VERSION = 3'd4;

   // Named character codes
   localparam char_type CH_A     = 6'd10;
   localparam char_type CH_C     = 6'd12;
   localparam char_type CH_E     = 6'd14;
   localparam char_type CH_F     = 6'd15;
   localparam char_type CH_I     = 6'd16;
   localparam char_type CH_L     = 6'd17;
   localparam char_type CH_N     = 6'd18;
   localparam char_type CH_O     = 6'd19;
   localparam char_type CH_R     = 6'd20;
   localparam char_type CH_S     = 6'd21;
   localparam char_type CH_T     = 6'd22;
   localparam char_type CH_U     = 6'd23;
   localparam char_type CH_DEG   = 6'd24;
   localparam char_type CH_BLANK = 6'd25;
   localparam char_type CH_MINUS = 6'd26;

   // Step counter milestones
   localparam logic [6:0] STEP_TEMP_REQ   = 7'd110;
   localparam logic [6:0] STEP_TEMP_RSP   = 7'd120;
   localparam logic [7:0] STEP_FLASH_END  = 8'd10;
   localparam logic [7:0] STEP_VERSION_END = 8'd8;

   // Display mode state, one-hot
   typedef enum logic [2:0] {
      DISP_FLASH   = 3'b001,
      DISP_NORMAL  = 3'b010,
      DISP_VERSION = 3'b100
   } mode_type;

   // Draw command handed from front to back
   typedef struct packed {
      logic               frame_valid;
      char_type [5:0]     chars;
      logic     [5:0]     flags;
      logic               temp_req;
      logic               temp_rsp;
   } cmd_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Segment pattern of a character code; codes past the table draw blank
   function automatic logic [7:0] glyph_of(input char_type c);
      logic [7:0] g;
      case (c)
         6'd0:    g = 8'hEB;
         6'd1:    g = 8'h60;
         6'd2:    g = 8'hC7;
         6'd3:    g = 8'hE5;
         6'd4:    g = 8'h6C;
         6'd5:    g = 8'hAD;
         6'd6:    g = 8'hAF;
         6'd7:    g = 8'hE0;
         6'd8:    g = 8'hEF;
         6'd9:    g = 8'hED;
         6'd10:   g = 8'hEE;
         6'd11:   g = 8'h2F;
         6'd12:   g = 8'h8B;
         6'd13:   g = 8'h67;
         6'd14:   g = 8'h8F;
         6'd15:   g = 8'h8E;
         6'd16:   g = 8'h60;
         6'd17:   g = 8'h0B;
         6'd18:   g = 8'hEA;
         6'd19:   g = 8'hEB;
         6'd20:   g = 8'h8A;
         6'd21:   g = 8'hAD;
         6'd22:   g = 8'h0F;
         6'd23:   g = 8'h6B;
         6'd24:   g = 8'hCC;
         6'd25:   g = 8'h00;
         6'd26:   g = 8'h04;
         6'd27:   g = 8'h80;
         6'd28:   g = 8'h40;
         6'd29:   g = 8'h20;
         6'd30:   g = 8'h01;
         6'd31:   g = 8'h02;
         6'd32:   g = 8'h08;
         6'd33:   g = 8'h04;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   // Flash words, leftmost character in element 0
   function automatic char_type [5:0] word_chars(input logic [1:0] idx);
      char_type [5:0] w;
      case (idx)
         2'd0:    w = {CH_E, CH_S, CH_R, CH_A, CH_O, CH_C};
         2'd1:    w = {CH_BLANK, CH_T, CH_L, CH_U, CH_A, CH_F};
         2'd2:    w = {CH_BLANK, CH_E, CH_N, CH_I, CH_F, CH_BLANK};
         default: w = {CH_R, CH_O, CH_S, CH_N, CH_E, CH_S};
      endcase
      return w;
   endfunction

   // Two decimal digits of frac * 100 / 16, tenths in the high nibble
   function automatic logic [7:0] frac_digits(input logic [3:0] frac);
      logic [7:0] d;
      case (frac)
         4'd0:    d = 8'h00;
         4'd1:    d = 8'h06;
         4'd2:    d = 8'h12;
         4'd3:    d = 8'h18;
         4'd4:    d = 8'h25;
         4'd5:    d = 8'h31;
         4'd6:    d = 8'h37;
         4'd7:    d = 8'h43;
         4'd8:    d = 8'h50;
         4'd9:    d = 8'h56;
         4'd10:   d = 8'h62;
         4'd11:   d = 8'h68;
         4'd12:   d = 8'h75;
         4'd13:   d = 8'h81;
         4'd14:   d = 8'h87;
         default: d = 8'h93;
      endcase
      return d;
   endfunction

endpackage

### design/sdmc_req_if.sv
// ----------------------------------------------------------------------------
// sdmc_req_if: request channel of the segment display mode controller
// Valid/ready channel carrying one operation beat and its operands.
// ----------------------------------------------------------------------------
interface sdmc_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  operation;
   logic signed [8:0]  speed_value;
   logic        [1:0]  message_index;
   logic signed [11:0] temperature;
   logic        [5:0]  rotate_char;
   logic        [5:0]  anim_flags;

   modport source (
      output valid, operation, speed_value, message_index, temperature,
             rotate_char, anim_flags,
      input  ready
   );

   modport sink (
      input  valid, operation, speed_value, message_index, temperature,
             rotate_char, anim_flags,
      output ready
   );
endinterface

### design/sdmc_rsp_if.sv
// ----------------------------------------------------------------------------
// sdmc_rsp_if: response channel of the segment display mode controller
// Valid/ready channel carrying one frame beat: bitmap and sensor pulses.
// ----------------------------------------------------------------------------
interface sdmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_valid;
   logic [7:0] seg_byte0;
   logic [7:0] seg_byte1;
   logic [7:0] seg_byte2;
   logic [7:0] seg_byte3;
   logic [7:0] seg_byte4;
   logic [7:0] seg_byte5;
   logic [7:0] seg_byte6;
   logic       temp_request_pulse;
   logic       temp_response_pulse;

   modport source (
      output valid, frame_valid, seg_byte0, seg_byte1, seg_byte2, seg_byte3,
             seg_byte4, seg_byte5, seg_byte6, temp_request_pulse,
             temp_response_pulse,
      input  ready
   );

   modport sink (
      input  valid, frame_valid, seg_byte0, seg_byte1, seg_byte2, seg_byte3,
             seg_byte4, seg_byte5, seg_byte6, temp_request_pulse,
             temp_response_pulse,
      output ready
   );
endinterface

### design/segment_display_mode_controller_top.sv
// ----------------------------------------------------------------------------
// segment_display_mode_controller_top: six-digit segment display controller
//
// Channels: req_bus (sink) takes one beat per event: tick, speed update,
// flash message, temperature or show version. rsp_bus (source) returns
// exactly one beat per request: frame_valid, seven bitmap bytes and the
// temperature request/response pulses. csr_wr_en/csr_wr_data load the
// 24-bit version register; write it only while the block is idle.
// Path: an accepted request is written into the command queue as a draw
// command, then rendered from the queue head into the response register.
// Throughput: one beat per cycle while the receiver keeps ready high;
// decode, digit conversion and rendering are combinational. The command
// queue (QUEUE_DEPTH entries) between decode and render absorbs the beat
// in flight when the receiver stalls; after that the requester waits too.
// Reset (synchronous): version mode, step zero, buffers cleared, version
// register zero, queue and response register empty.
// Receiver stall: the response register holds its beat, the queue fills,
// and req_bus.ready drops once QUEUE_DEPTH commands wait.
// ----------------------------------------------------------------------------
module segment_display_mode_controller_top
   import sdmc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic        clock,
   input  logic        reset,
   sdmc_req_if.sink    req_bus,
   sdmc_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   logic          push;
   logic          pop;
   cmd_type       push_cmd;
   cmd_type       head_cmd;
   q_status_type  q_status;

   sdmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   sdmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   sdmc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   // An accepted beat leaves a command queued on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !q_status.empty)
      else $error("accepted beat not queued");

   // Sensor pulses only ride on drawn frames
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.temp_request_pulse || rsp_bus.temp_response_pulse))
      |-> rsp_bus.frame_valid)
      else $error("pulse without frame");

   // Request and response pulses never coincide
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.temp_request_pulse && rsp_bus.temp_response_pulse))
      else $error("both pulses set");

   // An undrawn beat carries an empty bitmap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.frame_valid) |->
      (rsp_bus.seg_byte0 == 8'h00 && rsp_bus.seg_byte2 == 8'h00 &&
       rsp_bus.seg_byte4 == 8'h00 && rsp_bus.seg_byte6 == 8'h00))
      else $error("bitmap set without frame");
`endif

endmodule

### design/sdmc_front.sv
// ----------------------------------------------------------------------------
// sdmc_front: request decode and display state
// Accepts request beats, updates mode, step counter and character buffers,
// converts speed and temperature to digits and pushes one draw command.
// ----------------------------------------------------------------------------
module sdmc_front
   import sdmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   sdmc_req_if.sink         req_bus,
   input  logic             csr_wr_en,
   input  logic [23:0]      csr_wr_data,
   input  q_status_type     q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   // Split a value below 100 into tens and ones; tens by reciprocal multiply
   function automatic logic [7:0] split_tens(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   mode_type       mode_ff, mode_in;
   logic [7:0]     step_ff, step_in;
   char_type [5:0] normal_chars_ff, normal_chars_in;
   char_type [5:0] flash_chars_ff, flash_chars_in;
   logic           flash_colon_ff, flash_colon_in;
   logic [23:0]    version_ff;

   logic           accept;
   logic [7:0]     step_inc;

   logic [8:0]     spd;
   logic [8:0]     spd_mag;
   logic [7:0]     spd_sat;
   logic [3:0]     spd_hund;
   logic [6:0]     spd_rem;
   logic [7:0]     spd_to;
   char_type       spd_sign;
   char_type [5:0] speed_chars;

   logic [11:0]    tmp;
   logic [11:0]    tmp_mag;
   logic [7:0]     tmp_whole;
   logic [6:0]     tmp_rem;
   logic [7:0]     tmp_to;
   logic [7:0]     tmp_frac;
   char_type [5:0] temp_chars;

   char_type [5:0] version_chars;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && !q_status.full;
   assign step_inc      = step_ff + 8'd1;

   // Speed: magnitude with saturation, then sign-padded decimal
   always_comb begin
      spd      = req_bus.speed_value;
      spd_mag  = spd[8] ? (~spd + 9'd1) : spd;
      spd_sat  = spd_mag[8] ? 8'hFF : spd_mag[7:0];
      spd_sign = spd[8] ? CH_MINUS : CH_BLANK;
      if (spd_sat >= 8'd200) begin
         spd_hund = 4'd2;
         spd_rem  = 7'(spd_sat - 8'd200);
      end else if (spd_sat >= 8'd100) begin
         spd_hund = 4'd1;
         spd_rem  = 7'(spd_sat - 8'd100);
      end else begin
         spd_hund = 4'd0;
         spd_rem  = spd_sat[6:0];
      end
      spd_to = split_tens(spd_rem);

      speed_chars[0] = req_bus.rotate_char;
      speed_chars[4] = char_type'(spd_to[3:0]);
      speed_chars[5] = CH_BLANK;
      if (spd_hund != 4'd0) begin
         speed_chars[1] = spd_sign;
         speed_chars[2] = char_type'(spd_hund);
         speed_chars[3] = char_type'(spd_to[7:4]);
      end else if (spd_to[7:4] != 4'd0) begin
         speed_chars[1] = CH_BLANK;
         speed_chars[2] = spd_sign;
         speed_chars[3] = char_type'(spd_to[7:4]);
      end else if (spd_to[3:0] != 4'd0) begin
         speed_chars[1] = CH_BLANK;
         speed_chars[2] = CH_BLANK;
         speed_chars[3] = spd_sign;
      end else begin
         speed_chars[1] = CH_BLANK;
         speed_chars[2] = CH_BLANK;
         speed_chars[3] = CH_BLANK;
      end
   end

   // Temperature: drop hundreds, two integer and two fraction digits
   always_comb begin
      tmp       = req_bus.temperature;
      tmp_mag   = tmp[11] ? (~tmp + 12'd1) : tmp;
      tmp_whole = tmp_mag[11:4];
      tmp_rem   = (tmp_whole >= 8'd100) ? 7'(tmp_whole - 8'd100) : tmp_whole[6:0];
      tmp_to    = split_tens(tmp_rem);
      tmp_frac  = frac_digits(tmp_mag[3:0]);

      if (tmp_to[7:4] == 4'd0) begin
         temp_chars[0] = tmp[11] ? CH_MINUS : CH_BLANK;
      end else begin
         temp_chars[0] = char_type'(tmp_to[7:4]);
      end
      temp_chars[1] = char_type'(tmp_to[3:0]);
      temp_chars[2] = char_type'(tmp_frac[7:4]);
      temp_chars[3] = char_type'(tmp_frac[3:0]);
      temp_chars[4] = CH_DEG;
      temp_chars[5] = CH_C;
   end

   // Version digits, most significant nibble leftmost
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         version_chars[i] = char_type'(version_ff[23 - 4 * i -: 4]);
      end
   end

   // Decode the operation: next state and draw command
   always_comb begin
      mode_in         = mode_ff;
      step_in         = step_ff;
      normal_chars_in = normal_chars_ff;
      flash_chars_in  = flash_chars_ff;
      flash_colon_in  = flash_colon_ff;
      push_cmd        = '0;
      case (req_bus.operation)
         OP_TICK: begin
            step_in = step_inc;
            case (mode_ff)
               DISP_NORMAL: begin
                  normal_chars_in[0]   = req_bus.rotate_char;
                  push_cmd.frame_valid = 1'b1;
                  push_cmd.chars       = normal_chars_in;
                  push_cmd.flags       = req_bus.anim_flags;
                  push_cmd.temp_req    = (step_inc[6:0] == STEP_TEMP_REQ);
                  push_cmd.temp_rsp    = (step_inc[6:0] == STEP_TEMP_RSP);
               end
               DISP_FLASH: begin
                  if (step_inc < STEP_FLASH_END) begin
                     push_cmd.frame_valid = 1'b1;
                     push_cmd.chars       = flash_chars_ff;
                     push_cmd.flags       = req_bus.anim_flags | {5'd0, flash_colon_ff};
                  end else begin
                     mode_in              = DISP_NORMAL;
                     step_in              = 8'd0;
                     normal_chars_in[0]   = req_bus.rotate_char;
                     push_cmd.frame_valid = 1'b1;
                     push_cmd.chars       = normal_chars_in;
                     push_cmd.flags       = req_bus.anim_flags;
                  end
               end
               DISP_VERSION: begin
                  if (step_inc == STEP_VERSION_END) begin
                     mode_in              = DISP_NORMAL;
                     step_in              = 8'd0;
                     normal_chars_in      = speed_chars;
                     push_cmd.frame_valid = 1'b1;
                     push_cmd.chars       = speed_chars;
                     push_cmd.flags       = req_bus.anim_flags;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_SPEED: begin
            mode_in              = DISP_NORMAL;
            step_in              = 8'd0;
            normal_chars_in      = speed_chars;
            push_cmd.frame_valid = 1'b1;
            push_cmd.chars       = speed_chars;
            push_cmd.flags       = req_bus.anim_flags;
         end
         OP_FLASH: begin
            mode_in              = DISP_FLASH;
            step_in              = 8'd0;
            flash_colon_in       = 1'b0;
            flash_chars_in       = word_chars(req_bus.message_index);
            push_cmd.frame_valid = 1'b1;
            push_cmd.chars       = flash_chars_in;
            push_cmd.flags       = req_bus.anim_flags;
         end
         OP_TEMP: begin
            mode_in              = DISP_FLASH;
            step_in              = 8'd0;
            flash_colon_in       = 1'b1;
            flash_chars_in       = temp_chars;
            push_cmd.frame_valid = 1'b1;
            push_cmd.chars       = temp_chars;
            push_cmd.flags       = req_bus.anim_flags | 6'd1;
         end
         OP_VERSION: begin
            mode_in              = DISP_VERSION;
            step_in              = 8'd0;
            normal_chars_in      = version_chars;
            push_cmd.frame_valid = 1'b1;
            push_cmd.chars       = version_chars;
            push_cmd.flags       = 6'd0;
         end
         default: begin
         end
      endcase
   end

   assign push = accept;

   // Commit state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= DISP_VERSION;
         step_ff         <= 8'd0;
         normal_chars_ff <= '0;
         flash_chars_ff  <= '0;
         flash_colon_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         step_ff         <= step_in;
         normal_chars_ff <= normal_chars_in;
         flash_chars_ff  <= flash_chars_in;
         flash_colon_ff  <= flash_colon_in;
      end
   end

   // Hold the version register
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 24'd0;
      end else if (csr_wr_en) begin
         version_ff <= csr_wr_data;
      end
   end

endmodule

### design/sdmc_queue.sv
// ----------------------------------------------------------------------------
// sdmc_queue: draw command queue
// Small circular buffer that decouples request decode from frame rendering.
// ----------------------------------------------------------------------------
module sdmc_queue
   import sdmc_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   input  logic          pop,
   output cmd_type       head_cmd,
   output q_status_type  q_status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_cmd       = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/sdmc_back.sv
// ----------------------------------------------------------------------------
// sdmc_back: frame renderer and response register
// Looks up segment patterns, splits them over the bitmap bytes, ORs in the
// flag bits and holds the finished beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sdmc_back
   import sdmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       head_cmd,
   input  q_status_type  q_status,
   output logic          pop,
   sdmc_rsp_if.source    rsp_bus
);

   logic [7:0] glyph [6];
   logic [7:0] bm    [7];

   logic       rsp_valid_ff;
   logic       frame_valid_ff;
   logic [7:0] bm_ff [7];
   logic       temp_req_ff;
   logic       temp_rsp_ff;

   // Take the head when the output register is free or being drained
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_bus.ready);

   // Render the bitmap; no frame means all zero
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         glyph[i] = glyph_of(head_cmd.chars[i]);
      end
      bm[0] = {4'h0, glyph[0][3:0]};
      for (int i = 1; i < 6; i++) begin
         bm[i] = {glyph[i-1][7:4], glyph[i][3:0]};
      end
      bm[6] = {glyph[5][7:4], 4'h0};
      bm[2][4] = bm[2][4] | head_cmd.flags[0];
      bm[4][4] = bm[4][4] | head_cmd.flags[1];
      bm[0][7] = bm[0][7] | head_cmd.flags[2];
      bm[0][6] = bm[0][6] | head_cmd.flags[3];
      bm[0][5] = bm[0][5] | head_cmd.flags[4];
      bm[0][4] = bm[0][4] | head_cmd.flags[5];
      if (!head_cmd.frame_valid) begin
         for (int i = 0; i < 7; i++) begin
            bm[i] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         frame_valid_ff <= head_cmd.frame_valid;
         bm_ff          <= bm;
         temp_req_ff    <= head_cmd.frame_valid && head_cmd.temp_req;
         temp_rsp_ff    <= head_cmd.frame_valid && head_cmd.temp_rsp;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.frame_valid         = frame_valid_ff;
   assign rsp_bus.seg_byte0           = bm_ff[0];
   assign rsp_bus.seg_byte1           = bm_ff[1];
   assign rsp_bus.seg_byte2           = bm_ff[2];
   assign rsp_bus.seg_byte3           = bm_ff[3];
   assign rsp_bus.seg_byte4           = bm_ff[4];
   assign rsp_bus.seg_byte5           = bm_ff[5];
   assign rsp_bus.seg_byte6           = bm_ff[6];
   assign rsp_bus.temp_request_pulse  = temp_req_ff;
   assign rsp_bus.temp_response_pulse = temp_rsp_ff;

endmodule
